/* design/ccr_pkg.sv */
package ccr_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int PHASE_W      = 20;
  localparam int FRAC_W       = SAMPLE_W - 2;
  localparam int GUARD_W      = 4;
  localparam int CORDIC_STEPS = SAMPLE_W + 2;
  localparam int CNT_W        = $clog2(CORDIC_STEPS);
  localparam int XY_W         = SAMPLE_W + GUARD_W + 4;
  localparam int Z_W          = 34;
  localparam int MUL_A_W      = 31;
  localparam int MUL_B_W      = 32;
  localparam int PROD_W       = MUL_A_W + MUL_B_W + 1;
  localparam int ERR_W        = 2 * FRAC_W + 2;
  localparam int DET_W        = 2 * SAMPLE_W + 2;
  localparam int T_W          = 26;
  localparam int STEP_W       = PHASE_W + 1;
  localparam int GAIN_W       = 16;
  localparam int LIMIT_W      = PHASE_W - 1;
  localparam int ORDER_W      = 2;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = LIMIT_W;

  localparam int ROT_SHIFT    = 32 + GUARD_W;
  localparam int GAIN_SHIFT   = 2 * FRAC_W - 8;
  localparam int STEP_SHIFT   = 56 - PHASE_W;

  localparam logic [15:0] INV_GAIN_HI = 16'h9B74;
  localparam logic [15:0] INV_GAIN_LO = 16'hEDA8;
  localparam logic [31:0] INV_TWO_PI  = 32'd683565276;
  localparam longint      K8_Q32      = 64'd1779033704;
  localparam logic [15:0] K8_COEF     =
    16'((K8_Q32 + (64'd1 << (31 - FRAC_W))) >> (32 - FRAC_W));

  // detector order codes, the unused codes act as order 8
  localparam logic [ORDER_W-1:0] DET_ORDER2 = 2'd0;
  localparam logic [ORDER_W-1:0] DET_ORDER4 = 2'd1;

  localparam logic [CFG_ADDR_W-1:0] REG_DETECTOR = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ALPHA    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BETA     = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LIMIT    = 2'd3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 19'd166886;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CORDIC, ST_XH, ST_XL, ST_YH, ST_YL, ST_RQ, ST_DMUL, ST_DERR,
    ST_BMUL, ST_BRND, ST_BINV, ST_BSTEP, ST_ARND, ST_AINV, ST_ASTEP
  } ccr_state_e;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } ccr_mul_req_t;

  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic [GAIN_W-1:0]  alpha;
    logic [GAIN_W-1:0]  beta;
  } ccr_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] rot_i;
    logic signed [SAMPLE_W-1:0] rot_q;
    logic signed [STEP_W-1:0]   step_a;
    logic signed [STEP_W-1:0]   step_b;
  } ccr_res_t;

  function automatic logic [31:0] atan_turns(input logic [CNT_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

/* design/costas_carrier_recovery.sv */
// Costas carrier recovery for BPSK, QPSK and 8PSK signals.
// s_axis carries one complex sample per transaction: tdata holds the I and
// Q samples (signed Q1.14), tuser the sense tag and its value. m_axis
// returns the derotated sample, the loop frequency after the update, the
// echoed tag and the sensing state, one transaction per input.
// The cfg channel writes the detector order, the two loop gains and the
// frequency limit; write it only while no sample is in flight.
// An accepted sample passes through a CORDIC that iterates one micro-rotation
// per cycle, then a single shared multiplier handles the gain correction,
// the phase detector and both loop gains in sequence. The result is
// registered as the engine leaves its last state, and s_axis_tready is high
// again from that same edge, so no new sample is taken before the result of
// the previous sample is registered. The loop phase feedback requires this:
// each sample needs the phase left by the one before it.
// A finished result waits in the output register; if the receiver stalls,
// the engine holds its result and the next sample is refused until the
// output register is free.
// Reset clears the NCO phase and frequency, the saved copies and sensing,
// and loads the default register values: order 4, zero gains, one radian.
module costas_carrier_recovery import ccr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,  // sample_i, sample_q
  input  logic [1:0]            s_axis_tuser,  // tag_present, tag_sensing
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [55:0]           m_axis_tdata,  // rotated_i, rotated_q, loop_freq
  output logic [1:0]            m_axis_tuser,  // tag_echo, sensing_flag
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [ORDER_W-1:0] order_q;
  logic [GAIN_W-1:0] alpha_q, beta_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [PHASE_W-1:0] nco_phase_q, saved_phase_q;
  logic signed [PHASE_W-1:0] nco_freq_q, saved_freq_q;
  logic sensing_q, tag_q;
  logic out_valid_q;
  logic signed [SAMPLE_W-1:0] out_i_q, out_q_q;
  logic signed [PHASE_W-1:0] out_freq_q;
  logic out_tag_q, out_sense_q;

  logic accept, idle, done, ack, tag_in, sense_in;
  logic [PHASE_W-1:0] start_phase;
  ccr_cfg_t cfg;
  ccr_res_t res;

  assign cfg_ready_o = 1'b1;
  assign tag_in   = s_axis_tuser[0];
  assign sense_in = s_axis_tuser[1];
  assign s_axis_tready = idle;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign ack = done && (!out_valid_q || m_axis_tready);
  assign start_phase = (tag_in && !sense_in) ? saved_phase_q : nco_phase_q;
  assign cfg = '{order: order_q, alpha: alpha_q, beta: beta_q};

  ccr_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .sample_i_i ($signed(s_axis_tdata[15:0])),
    .sample_q_i ($signed(s_axis_tdata[31:16])),
    .phase_i    (start_phase),
    .sensing_i  (sensing_q),
    .cfg_i      (cfg),
    .ack_i      (ack),
    .idle_o     (idle),
    .done_o     (done),
    .res_o      (res)
  );

  logic signed [PHASE_W+1:0] freq_sum, lim_ext;
  logic [PHASE_W-1:0] phase_next;
  logic signed [PHASE_W-1:0] freq_clip;

  always_comb begin
    freq_sum = (PHASE_W+2)'(nco_freq_q) + (PHASE_W+2)'(res.step_b);
    lim_ext = $signed((PHASE_W+2)'(limit_q));
    phase_next = nco_phase_q + freq_sum[PHASE_W-1:0] + res.step_a[PHASE_W-1:0];
    if (freq_sum > lim_ext) freq_clip = lim_ext[PHASE_W-1:0];
    else if (freq_sum < -lim_ext) freq_clip = PHASE_W'(-lim_ext);
    else freq_clip = freq_sum[PHASE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q       <= DET_ORDER4;
      alpha_q       <= '0;
      beta_q        <= '0;
      limit_q       <= LIMIT_RESET;
      nco_phase_q   <= '0;
      nco_freq_q    <= '0;
      saved_phase_q <= '0;
      saved_freq_q  <= '0;
      sensing_q     <= 1'b0;
      tag_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          REG_DETECTOR: order_q <= cfg_data_i[ORDER_W-1:0];
          REG_ALPHA:    alpha_q <= cfg_data_i[GAIN_W-1:0];
          REG_BETA:     beta_q  <= cfg_data_i[GAIN_W-1:0];
          REG_LIMIT:    limit_q <= cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      // the tag acts before its own sample is rotated
      if (accept) begin
        tag_q <= tag_in;
        if (tag_in) begin
          sensing_q <= sense_in;
          if (sense_in) begin
            saved_phase_q <= nco_phase_q;
            saved_freq_q  <= nco_freq_q;
          end else begin
            nco_phase_q <= saved_phase_q;
            nco_freq_q  <= saved_freq_q;
          end
        end
      end
      if (ack) begin
        nco_phase_q <= phase_next;
        nco_freq_q  <= freq_clip;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) begin
      out_i_q     <= res.rot_i;
      out_q_q     <= res.rot_q;
      out_freq_q  <= freq_clip;
      out_tag_q   <= tag_q;
      out_sense_q <= sensing_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_freq_q, out_q_q, out_i_q};
  assign m_axis_tuser  = {out_sense_q, out_tag_q};

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("input taken while a sample is in flight");
  a_ack_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ack |-> (!out_valid_q || m_axis_tready))
    else $error("result written over a waiting transaction");
  a_done_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !idle)
    else $error("engine reports done while idle");
`endif

endmodule

/* design/ccr_mul.sv */
module ccr_mul import ccr_pkg::*; (
  input  logic                     clk_i,
  input  ccr_mul_req_t             req_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(req_i.a * req_i.b);
  end

  assign prod_o = prod_q;

endmodule

/* design/ccr_engine.sv */
module ccr_engine import ccr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [SAMPLE_W-1:0] sample_i_i,
  input  logic signed [SAMPLE_W-1:0] sample_q_i,
  input  logic [PHASE_W-1:0]         phase_i,
  input  logic                       sensing_i,
  input  ccr_cfg_t                   cfg_i,
  input  logic                       ack_i,
  output logic                       idle_o,
  output logic                       done_o,
  output ccr_res_t                   res_o
);

  localparam logic signed [Z_W-1:0]    QUARTER   = Z_W'(64'd1 << 30);
  localparam logic signed [Z_W-1:0]    HALF_TURN = Z_W'(64'd1 << 31);
  localparam logic signed [PROD_W-1:0] RND_ROT   = PROD_W'(64'd1 << (ROT_SHIFT - 1));
  localparam logic signed [PROD_W-1:0] RND_GAIN  = PROD_W'(64'd1 << (GAIN_SHIFT - 1));
  localparam logic signed [PROD_W-1:0] RND_STEP  = PROD_W'(64'd1 << (STEP_SHIFT - 1));
  localparam logic signed [PROD_W-1:0] S_MAX     = PROD_W'((64'd1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] S_MIN     = -S_MAX - PROD_W'(1);
  localparam logic signed [DET_W-1:0]  ERR_ONE   = DET_W'(64'd1 << (2 * FRAC_W));

  ccr_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic signed [XY_W-1:0] x_q, y_q;
  logic signed [Z_W-1:0] z_q;
  logic signed [PROD_W-1:0] acc_q;
  logic signed [SAMPLE_W-1:0] ri_q, rq_q;
  logic signed [ERR_W-1:0] err_q;
  logic signed [T_W-1:0] t_q;
  logic signed [STEP_W-1:0] step_b_q;

  ccr_mul_req_t req;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rot_sum;

  ccr_mul u_mul (.clk_i(clk_i), .req_i(req), .prod_o(prod));

  function automatic logic signed [SAMPLE_W-1:0] sat_round(
    input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] r;
    r = (v + RND_ROT) >>> ROT_SHIFT;
    if (r > S_MAX) return S_MAX[SAMPLE_W-1:0];
    if (r < S_MIN) return S_MIN[SAMPLE_W-1:0];
    return r[SAMPLE_W-1:0];
  endfunction

  // detector helpers on the registered rotated sample
  logic i_pos, q_pos, i_major;
  logic signed [DET_W-1:0] ii, qq, mm, si_q, sq_i, si_m, sq_m, det_e;
  logic signed [SAMPLE_W:0] abs_i, abs_q;

  always_comb begin
    ii = DET_W'(ri_q);
    qq = DET_W'(rq_q);
    mm = prod[DET_W-1:0];
    i_pos = (ri_q != '0) && !ri_q[SAMPLE_W-1];
    q_pos = (rq_q != '0) && !rq_q[SAMPLE_W-1];
    abs_i = ri_q[SAMPLE_W-1] ? -(SAMPLE_W+1)'(ri_q) : (SAMPLE_W+1)'(ri_q);
    abs_q = rq_q[SAMPLE_W-1] ? -(SAMPLE_W+1)'(rq_q) : (SAMPLE_W+1)'(rq_q);
    i_major = abs_i >= abs_q;
    si_q = i_pos ? qq : -qq;
    sq_i = q_pos ? ii : -ii;
    si_m = i_pos ? mm : -mm;
    sq_m = q_pos ? mm : -mm;
    case (cfg_i.order)
      DET_ORDER2: det_e = mm;
      DET_ORDER4: det_e = (si_q - sq_i) <<< FRAC_W;
      default:    det_e = i_major ? (si_q <<< FRAC_W) - sq_m : si_m - (sq_i <<< FRAC_W);
    endcase
  end

  assign rot_sum = acc_q + prod;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_CORDIC;
      ST_CORDIC: if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) state_d = ST_XH;
      ST_XH:     state_d = ST_XL;
      ST_XL:     state_d = ST_YH;
      ST_YH:     state_d = ST_YL;
      ST_YL:     state_d = ST_RQ;
      ST_RQ:     state_d = ST_DMUL;
      ST_DMUL:   state_d = ST_DERR;
      ST_DERR:   state_d = ST_BMUL;
      ST_BMUL:   state_d = ST_BRND;
      ST_BRND:   state_d = ST_BINV;
      ST_BINV:   state_d = ST_BSTEP;
      ST_BSTEP:  state_d = ST_ARND;
      ST_ARND:   state_d = ST_AINV;
      ST_AINV:   state_d = ST_ASTEP;
      ST_ASTEP:  if (ack_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // multiplier operands and status
  always_comb begin
    req = '0;
    idle_o = 1'b0;
    done_o = 1'b0;
    case (state_q)
      ST_IDLE: idle_o = 1'b1;
      ST_XH: begin
        req.a = MUL_A_W'(x_q);
        req.b = $signed(MUL_B_W'(INV_GAIN_HI));
      end
      ST_XL: begin
        req.a = MUL_A_W'(x_q);
        req.b = $signed(MUL_B_W'(INV_GAIN_LO));
      end
      ST_YH: begin
        req.a = MUL_A_W'(y_q);
        req.b = $signed(MUL_B_W'(INV_GAIN_HI));
      end
      ST_YL: begin
        req.a = MUL_A_W'(y_q);
        req.b = $signed(MUL_B_W'(INV_GAIN_LO));
      end
      ST_DMUL: begin
        if (cfg_i.order == DET_ORDER2) begin
          req.a = MUL_A_W'(ri_q);
          req.b = MUL_B_W'(rq_q);
        end else begin
          req.a = i_major ? MUL_A_W'(ri_q) : MUL_A_W'(rq_q);
          req.b = $signed(MUL_B_W'(K8_COEF));
        end
      end
      ST_BMUL: begin
        req.a = MUL_A_W'(err_q);
        req.b = $signed(MUL_B_W'(cfg_i.beta));
      end
      ST_BINV, ST_AINV: begin
        req.a = MUL_A_W'(t_q);
        req.b = $signed(INV_TWO_PI);
      end
      ST_BSTEP: begin
        req.a = MUL_A_W'(err_q);
        req.b = $signed(MUL_B_W'(cfg_i.alpha));
      end
      ST_ASTEP: begin
        // hold the operands so the alpha step stays put while the output waits
        req.a = MUL_A_W'(t_q);
        req.b = $signed(INV_TWO_PI);
        done_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  logic [PHASE_W-1:0] neg_phase;
  logic signed [31:0] z32;
  logic signed [Z_W-1:0] z_init;
  logic signed [XY_W-1:0] x_init, y_init;

  always_comb begin
    neg_phase = -phase_i;
    z32 = $signed({neg_phase, {(32 - PHASE_W){1'b0}}});
    z_init = Z_W'(z32);
    x_init = XY_W'(sample_i_i) <<< GUARD_W;
    y_init = XY_W'(sample_q_i) <<< GUARD_W;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cnt_q <= '0;
        if (z_init > QUARTER) begin
          x_q <= -x_init;
          y_q <= -y_init;
          z_q <= z_init - HALF_TURN;
        end else if (z_init < -QUARTER) begin
          x_q <= -x_init;
          y_q <= -y_init;
          z_q <= z_init + HALF_TURN;
        end else begin
          x_q <= x_init;
          y_q <= y_init;
          z_q <= z_init;
        end
      end
      ST_CORDIC: begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (!z_q[Z_W-1]) begin
          x_q <= x_q - (y_q >>> cnt_q);
          y_q <= y_q + (x_q >>> cnt_q);
          z_q <= z_q - $signed(Z_W'(atan_turns(cnt_q)));
        end else begin
          x_q <= x_q + (y_q >>> cnt_q);
          y_q <= y_q - (x_q >>> cnt_q);
          z_q <= z_q + $signed(Z_W'(atan_turns(cnt_q)));
        end
      end
      ST_XL, ST_YL: acc_q <= prod <<< 16;
      ST_YH: ri_q <= sat_round(rot_sum);
      ST_RQ: rq_q <= sat_round(rot_sum);
      ST_DERR: begin
        if (sensing_i) err_q <= '0;
        else if (det_e > ERR_ONE) err_q <= ERR_ONE[ERR_W-1:0];
        else if (det_e < -ERR_ONE) err_q <= ERR_W'(-ERR_ONE);
        else err_q <= det_e[ERR_W-1:0];
      end
      ST_BRND, ST_ARND: t_q <= T_W'((prod + RND_GAIN) >>> GAIN_SHIFT);
      ST_BSTEP: step_b_q <= STEP_W'((prod + RND_STEP) >>> STEP_SHIFT);
      ST_AINV: ;
      default: ;
    endcase
  end

  // the alpha step lands in the cycle after its round-to-phase multiply
  logic signed [STEP_W-1:0] step_a;
  assign step_a = STEP_W'((prod + RND_STEP) >>> STEP_SHIFT);

  assign res_o.rot_i  = ri_q;
  assign res_o.rot_q  = rq_q;
  assign res_o.step_a = step_a;
  assign res_o.step_b = step_b_q;

endmodule
